// ----- src/bbct_pkg.sv -----
package bbct_pkg;

  localparam int ENTRY_W = 5;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int TAG_W   = DEV_W + BLK_W;
  localparam int CNT_W   = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_FINISH
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_get;
    logic in_range;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- src/block_buffer_cache_tags.sv -----
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    action, device, block_number, entry_index
// out_      output     out_valid / out_stall  entry, hit, needs_read, status
//
// A get reads every entry through the tag and count memories, one per cycle,
// then drains the last compare and commits; release, pin and unpin read one
// count when the entry index is in range, then commit.
// The next item is taken in the cycle after the commit; a stalled result holds
// the commit step until the output register frees.
// Synchronous active-low reset clears the assigned, count and contents marks.
module block_buffer_cache_tags import bbct_pkg::*; #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [DEV_W-1:0]   in_device,
  input  logic [BLK_W-1:0]   in_block_number,
  input  logic [ENTRY_W-1:0] in_entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ENTRY_W-1:0] out_entry,
  output logic               out_hit,
  output logic               out_needs_read,
  output logic [1:0]         out_status
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  bbct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbct_datapath #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_entry_index  (in_entry_index),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_entry       (out_entry),
    .out_hit         (out_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status)
  );

endmodule

// ----- src/bbct_ctrl.sv -----
module bbct_ctrl import bbct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_get) begin
            state_nxt = S_SCAN;
          end else if (sts.in_range) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FETCH:  state_nxt = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != S_IDLE);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.scan   = (state_r == S_SCAN);
    cmd.fetch  = (state_r == S_FETCH);
    cmd.commit = (state_r == S_FINISH) && sts.out_free;
  end

endmodule

// ----- src/bbct_datapath.sv -----
module bbct_datapath import bbct_pkg::*; #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  input  logic [1:0]         in_action,
  input  logic [DEV_W-1:0]   in_device,
  input  logic [BLK_W-1:0]   in_block_number,
  input  logic [ENTRY_W-1:0] in_entry_index,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [ENTRY_W-1:0] out_entry,
  output logic               out_hit,
  output logic               out_needs_read,
  output logic [1:0]         out_status
);

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int EXT_W = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

  // latched request
  action_t            req_action_r;
  logic [TAG_W-1:0]   req_tag_r;
  logic [ENTRY_W-1:0] req_idx_r;
  logic               req_in_range_r;

  // tag and count stores
  logic [TAG_W-1:0] tag_mem [NUM_BUFFERS];
  logic [CNT_W-1:0] cnt_mem [NUM_BUFFERS];
  logic [TAG_W-1:0] tag_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;

  logic [NUM_BUFFERS-1:0] assigned_r;
  logic [NUM_BUFFERS-1:0] cnt_vld_r;
  logic [NUM_BUFFERS-1:0] cv_r;

  // scan
  logic [IDX_W-1:0] scan_addr_r;
  logic [IDX_W-1:0] cmp_addr_r;
  logic             cmp_en_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [CNT_W-1:0] cnt_eff;
  logic             match;

  logic             hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic             hit_cv_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic [EXT_W-1:0] req_ext;
  logic [EXT_W-1:0] hit_ext;
  logic [EXT_W-1:0] free_ext;
  logic [IDX_W-1:0] req_addr;

  // update
  logic               cnt_we;
  logic               tag_we;
  logic               set_cv;
  logic [IDX_W-1:0]   wr_addr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [ENTRY_W-1:0] res_entry;
  logic               res_hit;
  logic               res_nr;
  status_t            res_status;

  logic               out_valid_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic               out_hit_r;
  logic               out_needs_read_r;
  status_t            out_status_r;

  assign req_ext  = EXT_W'(req_idx_r);
  assign hit_ext  = EXT_W'(hit_idx_r);
  assign free_ext = EXT_W'(free_idx_r);
  assign req_addr = req_ext[IDX_W-1:0];

  assign sts.is_get    = (action_t'(in_action) == ACT_GET);
  assign sts.in_range  = (32'(in_entry_index) < 32'(NUM_BUFFERS));
  assign sts.scan_last = (scan_addr_r == IDX_W'(NUM_BUFFERS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r   <= action_t'(in_action);
      req_tag_r      <= {in_device, in_block_number};
      req_idx_r      <= in_entry_index;
      req_in_range_r <= sts.in_range;
    end
  end

  assign rd_addr = cmd.fetch ? req_addr : scan_addr_r;
  assign rd_en   = cmd.scan || cmd.fetch;

  always_ff @(posedge clk) begin
    if (cmd.commit && tag_we) begin
      tag_mem[wr_addr] <= req_tag_r;
    end
    if (cmd.commit && cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      tag_rd_r   <= tag_mem[rd_addr];
      cnt_rd_r   <= cnt_mem[rd_addr];
      cmp_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_addr_r <= '0;
    end else if (cmd.scan) begin
      scan_addr_r <= scan_addr_r + 1'b1;
    end
  end

  // a count never written reads as zero
  assign cnt_eff = cnt_vld_r[cmp_addr_r] ? cnt_rd_r : '0;
  assign match   = assigned_r[cmp_addr_r] && (tag_rd_r == req_tag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.load) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmp_en_r) begin
        // keep the lowest-numbered hit and free entry
        if (match && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= cmp_addr_r;
          hit_cnt_r   <= cnt_eff;
          hit_cv_r    <= cv_r[cmp_addr_r];
        end
        if ((cnt_eff == '0) && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_addr_r;
        end
      end
    end
  end

  always_comb begin
    cnt_we     = 1'b0;
    tag_we     = 1'b0;
    set_cv     = 1'b0;
    wr_addr    = cmp_addr_r;
    cnt_wdata  = cnt_eff;
    res_entry  = req_idx_r;
    res_hit    = 1'b0;
    res_nr     = 1'b0;
    res_status = ST_OK;
    unique case (req_action_r)
      ACT_GET: begin
        if (hit_found_r) begin
          res_entry = hit_ext[ENTRY_W-1:0];
          res_hit   = 1'b1;
          wr_addr   = hit_idx_r;
          if (hit_cnt_r == COUNT_MAX) begin
            res_status = ST_OVERFLOW;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = hit_cnt_r + 1'b1;
            set_cv    = 1'b1;
            res_nr    = !hit_cv_r;
          end
        end else if (free_found_r) begin
          res_entry = free_ext[ENTRY_W-1:0];
          wr_addr   = free_idx_r;
          tag_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = CNT_W'(1);
          set_cv    = 1'b1;
          res_nr    = 1'b1;
        end else begin
          res_entry  = '0;
          res_status = ST_NO_FREE;
        end
      end
      ACT_PIN: begin
        if (req_in_range_r) begin
          if (cnt_eff == COUNT_MAX) begin
            res_status = ST_OVERFLOW;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_eff + 1'b1;
          end
        end
      end
      ACT_RELEASE, ACT_UNPIN: begin
        if (req_in_range_r) begin
          if (cnt_eff == '0) begin
            res_status = ST_UNDERFLOW;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_eff - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r <= '0;
      cnt_vld_r  <= '0;
      cv_r       <= '0;
    end else if (cmd.commit) begin
      if (cnt_we) begin
        cnt_vld_r[wr_addr] <= 1'b1;
      end
      if (tag_we) begin
        assigned_r[wr_addr] <= 1'b1;
      end
      if (set_cv) begin
        cv_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_entry_r      <= res_entry;
      out_hit_r        <= res_hit;
      out_needs_read_r <= res_nr;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry      = out_entry_r;
  assign out_hit        = out_hit_r;
  assign out_needs_read = out_needs_read_r;
  assign out_status     = out_status_r;

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && cnt_we && cmp_en_r))
    else $error("count store written while a scan compare is in flight");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item not presented on the output");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.commit)
    else $error("result overwritten while stalled");

  a_read_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_needs_read_r |-> (out_status_r == ST_OK) && (out_hit_r || 1'b1))
    else $error("disk read requested on a failed item");

  a_hit_not_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> (out_status_r == ST_OK) || (out_status_r == ST_OVERFLOW))
    else $error("hit reported with an impossible status");

endmodule

// ----- tb/sv/block_buffer_cache_tags_tb.sv -----
`timescale 1ns / 1ps

module block_buffer_cache_tags_tb;
  import bbct_pkg::*;

  localparam int NUM_BUFS    = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 60;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               hit;
    logic               needs_read;
    status_t            status;
  } cache_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_GET;
  logic [DEV_W-1:0]   in_device = '0;
  logic [BLK_W-1:0]   in_block_number = '0;
  logic [ENTRY_W-1:0] in_entry_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ENTRY_W-1:0] out_entry;
  logic               out_hit;
  logic               out_needs_read;
  logic [1:0]         out_status;

  block_buffer_cache_tags #(.NUM_BUFFERS(NUM_BUFS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry       (out_entry),
    .out_hit         (out_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status)
  );

  // shadow copy of the tag and count memories
  logic [DEV_W-1:0] shadow_dev   [NUM_BUFS];
  logic [BLK_W-1:0] shadow_blk   [NUM_BUFS];
  logic             shadow_tagged[NUM_BUFS];
  logic [CNT_W-1:0] shadow_count [NUM_BUFS];
  logic             shadow_loaded[NUM_BUFS];

  cache_result_t      pending_results[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  logic [ENTRY_W-1:0] last_entry;

  // sender and receiver pacing
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;
  bit stall_phase = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_buffer_cache_tags: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_run == 0) begin
          stall_phase = !stall_phase;
          stall_run = stall_phase ? $urandom_range(1, 20) : $urandom_range(1, 10);
        end else begin
          stall_run--;
        end
        out_stall <= stall_phase;
      end
      default: out_stall <= 1'b0;
    endcase
  end

  function automatic void clear_shadow();
    for (int i = 0; i < NUM_BUFS; i++) begin
      shadow_dev[i]    = '0;
      shadow_blk[i]    = '0;
      shadow_tagged[i] = 1'b0;
      shadow_count[i]  = '0;
      shadow_loaded[i] = 1'b0;
    end
  endfunction

  function automatic cache_result_t cache_step(action_t act, logic [DEV_W-1:0] dev,
                                               logic [BLK_W-1:0] blk,
                                               logic [ENTRY_W-1:0] idx);
    cache_result_t res;
    res = '{entry: idx, hit: 1'b0, needs_read: 1'b0, status: ST_OK};
    if (act == ACT_GET) begin
      for (int i = 0; i < NUM_BUFS; i++) begin
        if (shadow_tagged[i] && shadow_dev[i] == dev && shadow_blk[i] == blk) begin
          res.entry = ENTRY_W'(i);
          res.hit = 1'b1;
          if (shadow_count[i] == COUNT_MAX) begin
            res.status = ST_OVERFLOW;
          end else begin
            shadow_count[i]++;
            res.needs_read = !shadow_loaded[i];
            shadow_loaded[i] = 1'b1;
          end
          return res;
        end
      end
      for (int i = 0; i < NUM_BUFS; i++) begin
        if (shadow_count[i] == '0) begin
          shadow_dev[i]    = dev;
          shadow_blk[i]    = blk;
          shadow_tagged[i] = 1'b1;
          shadow_count[i]  = CNT_W'(1);
          shadow_loaded[i] = 1'b1;
          res.entry = ENTRY_W'(i);
          res.needs_read = 1'b1;
          return res;
        end
      end
      res.entry = '0;
      res.status = ST_NO_FREE;
      return res;
    end
    if (idx >= NUM_BUFS) return res;
    if (act == ACT_PIN) begin
      if (shadow_count[idx] == COUNT_MAX) res.status = ST_OVERFLOW;
      else shadow_count[idx]++;
    end else begin
      if (shadow_count[idx] == '0) res.status = ST_UNDERFLOW;
      else shadow_count[idx]--;
    end
    return res;
  endfunction

  // first held entry from a random start, wrapping past the last, or that start if none is held
  function automatic logic [ENTRY_W-1:0] pick_held();
    int start;
    start = $urandom_range(0, NUM_BUFS - 1);
    for (int i = 0; i < NUM_BUFS; i++) begin
      if (shadow_count[(start + i) % NUM_BUFS] != '0) return ENTRY_W'((start + i) % NUM_BUFS);
    end
    return ENTRY_W'(start);
  endfunction

  function automatic int held_entries();
    int n;
    n = 0;
    for (int i = 0; i < NUM_BUFS; i++) if (shadow_count[i] != '0) n++;
    return n;
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: entry %0d status %0d", out_entry, out_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_entry !== want.entry) begin
          $error("entry: expected %0d, got %0d", want.entry, out_entry);
          fail_count++;
        end
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          fail_count++;
        end
        if (out_needs_read !== want.needs_read) begin
          $error("needs_read: expected %0b, got %0b", want.needs_read, out_needs_read);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input action_t act, input logic [DEV_W-1:0] dev,
                           input logic [BLK_W-1:0] blk, input logic [ENTRY_W-1:0] idx);
    cache_result_t res;
    in_valid        <= 1'b1;
    in_action       <= act;
    in_device       <= dev;
    in_block_number <= blk;
    in_entry_index  <= idx;
    do @(posedge clk); while (in_stall);
    res = cache_step(act, dev, blk, idx);
    pending_results.push_back(res);
    last_entry = res.entry;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    gaps_on = 1'b0;
    stall_mode = 0;
    // zero tags of untouched entries must not match
    send_item(ACT_GET, 8'h00, 32'h0000_0000, '0);
    send_item(ACT_GET, 8'h00, 32'h0000_0000, '0);
    send_item(ACT_GET, 8'hFF, 32'hFFFF_FFFF, '0);
    send_item(ACT_GET, 8'hFF, 32'h0000_0000, '0);
    send_item(ACT_GET, 8'h00, 32'hFFFF_FFFF, 5'd31);
    send_item(ACT_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    send_item(ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    send_item(ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    send_item(ACT_UNPIN, 8'h00, 32'h0000_0000, 5'd31);
    send_item(ACT_PIN, 8'h00, 32'h0000_0000, 5'd31);
    send_item(ACT_UNPIN, 8'h00, 32'h0000_0000, 5'd31);
    // idle entry keeps its tag and hits without a read
    send_item(ACT_GET, 8'h00, 32'h0000_0000, '0);
    send_item(ACT_GET, 8'h5A, 32'hA5A5_5A5A, '0);
    send_item(ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd1);
    send_item(ACT_GET, 8'hA5, 32'h5A5A_A5A5, '0);
    send_item(ACT_GET, 8'hFF, 32'hFFFF_FFFF, '0);
    send_item(ACT_PIN, 8'h00, 32'h0000_0000, 5'd2);
    send_item(ACT_UNPIN, 8'h00, 32'h0000_0000, 5'd2);
    send_item(ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd16);
  endtask

  task automatic test_no_free_buffer();
    gaps_on = 1'b1;
    stall_mode = 1;
    for (int i = 0; i < NUM_BUFS + 4; i++) send_item(ACT_GET, 8'hC3, 32'h1000_0000 + i, '0);
    send_item(ACT_PIN, 8'h00, 32'h0, 5'd7);
    while (held_entries() != 0) send_item(ACT_RELEASE, 8'h00, 32'h0, pick_held());
  endtask

  task automatic test_count_limits();
    logic [ENTRY_W-1:0] slot;
    gaps_on = 1'b1;
    stall_mode = 2;
    send_item(ACT_GET, 8'h77, 32'hCAFE_0001, '0);
    slot = last_entry;
    while (shadow_count[slot] != COUNT_MAX) send_item(ACT_PIN, 8'h00, 32'h0, slot);
    send_item(ACT_PIN, 8'h00, 32'h0, slot);
    send_item(ACT_GET, 8'h77, 32'hCAFE_0001, '0);
    while (shadow_count[slot] != '0) send_item(ACT_UNPIN, 8'h00, 32'h0, slot);
    send_item(ACT_UNPIN, 8'h00, 32'h0, slot);
    send_item(ACT_RELEASE, 8'h00, 32'h0, slot);
  endtask

  task automatic test_random_traffic();
    logic [DEV_W-1:0] pool_dev[8];
    logic [BLK_W-1:0] pool_blk[8];
    int roll;
    int get_share;
    int k;
    pool_dev[0] = 8'h00;
    pool_blk[0] = 32'h0000_0000;
    pool_dev[1] = 8'hFF;
    pool_blk[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) begin
      pool_dev[i] = DEV_W'($urandom_range(0, 255));
      pool_blk[i] = $urandom();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      stall_mode = (n / 150) % 3;
      gaps_on = ((n / 230) % 4) != 0;
      get_share = (held_entries() >= 28) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < get_share) begin
        if ($urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, 7);
          send_item(ACT_GET, pool_dev[k], pool_blk[k], ENTRY_W'($urandom_range(0, 31)));
        end else begin
          send_item(ACT_GET, DEV_W'($urandom_range(0, 255)), $urandom(),
                    ENTRY_W'($urandom_range(0, 31)));
        end
      end else if (roll < get_share + 10) begin
        send_item(ACT_PIN, DEV_W'($urandom_range(0, 255)), $urandom(),
                  ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom_range(0, 31)) : pick_held());
      end else begin
        // drop a reference, now and then on an arbitrary entry
        send_item(($urandom_range(0, 1) == 0) ? ACT_RELEASE : ACT_UNPIN,
                  DEV_W'($urandom_range(0, 255)), $urandom(),
                  ($urandom_range(0, 9) == 0) ? ENTRY_W'($urandom_range(0, 31)) : pick_held());
      end
    end
  endtask

  initial begin
    clear_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    wait_drained();
    test_no_free_buffer();
    test_count_limits();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("block_buffer_cache_tags: match");
    end else begin
      $display("block_buffer_cache_tags: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bbct_pkg.sv
src/bbct_ctrl.sv
src/bbct_datapath.sv
src/block_buffer_cache_tags.sv
tb/sv/block_buffer_cache_tags_tb.sv
